>>> design/bfi_pkg.sv
`default_nettype none
package bfi_pkg;

    localparam int FILTER_BITS = 65536;
    localparam int MAX_HASHES  = 30;
    localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
    localparam int STORE_BITS  = STORE_BYTES * 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int POS_W       = $clog2(STORE_BITS);
    localparam int M_W         = POS_W + 1;
    localparam int K_W         = 5;
    localparam int CFG_W       = 17;
    localparam int HASH_W      = 32;
    localparam int ROT_RIGHT   = 17;
    localparam int MIN_BITS    = 64;
    localparam int LANES       = 3;
    localparam int MOD_ITERS   = HASH_W / 2;
    localparam int MOD_CNT_W   = $clog2(MOD_ITERS);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic REG_HASH_COUNT  = 1'b0;
    localparam logic REG_FILTER_BITS = 1'b1;

    localparam logic [K_W-1:0]   HASH_COUNT_RST  = K_W'(6);
    localparam logic [CFG_W-1:0] FILTER_BITS_RST = CFG_W'(65536);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_FIX,
        S_ADJ,
        S_PROBE,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage
`default_nettype wire

>>> design/bfi_mod.sv
`default_nettype none
module bfi_mod (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_start,
    input  wire logic [bfi_pkg::M_W-1:0]                    i_m,
    input  wire logic [bfi_pkg::LANES-1:0][bfi_pkg::HASH_W-1:0] i_div,
    output logic                                            o_done,
    output logic [bfi_pkg::LANES-1:0][bfi_pkg::POS_W-1:0]   o_rem
);

    logic                                              r_busy;
    logic                                              r_done;
    logic [bfi_pkg::MOD_CNT_W-1:0]                     r_cnt;
    logic [bfi_pkg::M_W-1:0]                           r_m;
    logic [bfi_pkg::LANES-1:0][bfi_pkg::HASH_W-1:0]    r_div;
    logic [bfi_pkg::LANES-1:0][bfi_pkg::POS_W-1:0]     r_rem;
    logic [bfi_pkg::LANES-1:0][bfi_pkg::POS_W-1:0]     n_rem;

    function automatic logic [bfi_pkg::POS_W-1:0] mod_step(
        input logic [bfi_pkg::POS_W-1:0] rem,
        input logic                      dbit,
        input logic [bfi_pkg::M_W-1:0]   m
    );
        logic [bfi_pkg::M_W-1:0] t;
        logic [bfi_pkg::M_W-1:0] s;
        t = {rem, dbit};
        s = (t >= m) ? (t - m) : t;
        return s[bfi_pkg::POS_W-1:0];
    endfunction

    always_comb begin
        for (int i = 0; i < bfi_pkg::LANES; i++) begin
            n_rem[i] = mod_step(mod_step(r_rem[i], r_div[i][bfi_pkg::HASH_W-1], r_m),
                                r_div[i][bfi_pkg::HASH_W-2], r_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == bfi_pkg::MOD_CNT_W'(bfi_pkg::MOD_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= i_m;
            r_div <= i_div;
            r_rem <= '0;
        end else if (r_busy) begin
            for (int i = 0; i < bfi_pkg::LANES; i++) begin
                r_div[i] <= {r_div[i][bfi_pkg::HASH_W-3:0], 2'b00};
            end
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

>>> design/bfi_ram.sv
`default_nettype none
module bfi_ram (
    input  wire logic              i_clk,
    input  wire bfi_pkg::t_ram_req i_req,
    output logic [7:0]             o_rdata
);

    logic [7:0] r_mem [bfi_pkg::STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> design/bfi_ctrl.sv
`default_nettype none
module bfi_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [bfi_pkg::HASH_W-1:0]    i_key_hash,
    input  wire logic                          i_key_empty,
    input  wire logic [bfi_pkg::M_W-1:0]       i_m,
    input  wire logic [bfi_pkg::K_W-1:0]       i_k,
    output logic                               o_busy,
    output logic                               o_valid,
    output logic                               o_maybe_present,
    output logic                               o_mod_start,
    output logic [bfi_pkg::LANES-1:0][bfi_pkg::HASH_W-1:0] o_mod_div,
    input  wire logic                          i_mod_done,
    input  wire logic [bfi_pkg::LANES-1:0][bfi_pkg::POS_W-1:0] i_mod_rem,
    output bfi_pkg::t_ram_req                  o_ram_req,
    input  wire logic [7:0]                    i_ram_rdata
);

    localparam int PW = bfi_pkg::POS_W;
    localparam int AW = bfi_pkg::ADDR_W;

    bfi_pkg::t_state            r_state;
    bfi_pkg::t_state            n_state;

    logic [1:0]                 r_op;
    logic                       r_clr_out;
    logic [AW-1:0]              r_clr;
    logic [bfi_pkg::HASH_W-1:0] r_hash;
    logic [bfi_pkg::HASH_W-1:0] r_delta;
    logic [bfi_pkg::M_W-1:0]    r_m;
    logic [bfi_pkg::K_W-1:0]    r_k;
    logic [bfi_pkg::K_W-1:0]    r_cnt;
    logic [PW-1:0]              r_pos;
    logic [PW-1:0]              r_d;
    logic [PW-1:0]              r_w;
    logic [PW-1:0]              r_dw;
    logic                       r_hit;
    logic                       r_p1_valid;
    logic [AW-1:0]              r_p1_addr;
    logic [2:0]                 r_p1_bit;
    logic                       r_wr_valid;
    logic [AW-1:0]              r_wr_addr;
    logic [7:0]                 r_wr_data;

    logic                       accept;
    logic                       need_probe;
    logic [bfi_pkg::HASH_W-1:0] delta_in;
    logic [bfi_pkg::HASH_W:0]   hsum;
    logic [bfi_pkg::M_W-1:0]    psum;
    logic [bfi_pkg::M_W-1:0]    pos_wrap;
    logic [PW-1:0]              pos_nxt;
    logic [bfi_pkg::M_W-1:0]    w_inc;
    logic [bfi_pkg::M_W-1:0]    dw_sum;
    logic [7:0]                 byte_cur;
    logic [7:0]                 byte_set;
    logic                       p1_write;

    assign accept     = (r_state == bfi_pkg::S_IDLE) && i_start;
    assign need_probe = (i_opcode == bfi_pkg::OP_INSERT) ||
                        ((i_opcode == bfi_pkg::OP_QUERY) && !i_key_empty);
    assign delta_in   = {i_key_hash[bfi_pkg::ROT_RIGHT-1:0],
                         i_key_hash[bfi_pkg::HASH_W-1:bfi_pkg::ROT_RIGHT]};

    assign hsum     = {1'b0, r_hash} + {1'b0, r_delta};
    assign psum     = {1'b0, r_pos} + {1'b0, (hsum[bfi_pkg::HASH_W] ? r_dw : r_d)};
    assign pos_wrap = (psum >= r_m) ? (psum - r_m) : psum;
    assign pos_nxt  = pos_wrap[PW-1:0];

    assign w_inc  = {1'b0, i_mod_rem[2]} + 1'b1;
    assign dw_sum = (r_d >= r_w) ? ({1'b0, r_d} - {1'b0, r_w})
                                 : ({1'b0, r_d} + r_m - {1'b0, r_w});

    assign byte_cur = (r_wr_valid && (r_wr_addr == r_p1_addr)) ? r_wr_data : i_ram_rdata;
    assign byte_set = byte_cur | (8'd1 << r_p1_bit);
    assign p1_write = r_p1_valid && (r_op == bfi_pkg::OP_INSERT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            bfi_pkg::S_CLEAR: begin
                if (r_clr == {AW{1'b1}}) begin
                    n_state = r_clr_out ? bfi_pkg::S_DONE : bfi_pkg::S_IDLE;
                end
            end
            bfi_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == bfi_pkg::OP_CLEAR) begin
                        n_state = bfi_pkg::S_CLEAR;
                    end else if (need_probe) begin
                        n_state = bfi_pkg::S_MOD;
                    end else begin
                        n_state = bfi_pkg::S_DONE;
                    end
                end
            end
            bfi_pkg::S_MOD: begin
                if (i_mod_done) begin
                    n_state = bfi_pkg::S_FIX;
                end
            end
            bfi_pkg::S_FIX:   n_state = bfi_pkg::S_ADJ;
            bfi_pkg::S_ADJ:   n_state = bfi_pkg::S_PROBE;
            bfi_pkg::S_PROBE: begin
                if (r_cnt == r_k - 1'b1) begin
                    n_state = bfi_pkg::S_DRAIN;
                end
            end
            bfi_pkg::S_DRAIN: n_state = bfi_pkg::S_DONE;
            bfi_pkg::S_DONE:  n_state = bfi_pkg::S_IDLE;
            default:          n_state = bfi_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_busy          = (r_state != bfi_pkg::S_IDLE);
        o_valid         = (r_state == bfi_pkg::S_DONE);
        o_maybe_present = (r_state == bfi_pkg::S_DONE) && r_hit;
        o_mod_start     = accept && need_probe;
        o_mod_div       = {{bfi_pkg::HASH_W{1'b1}}, delta_in, i_key_hash};
        o_ram_req.raddr = r_pos[PW-1:3];
        case (r_state)
            bfi_pkg::S_CLEAR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_clr;
                o_ram_req.wdata = 8'd0;
            end
            default: begin
                o_ram_req.we    = p1_write;
                o_ram_req.waddr = r_p1_addr;
                o_ram_req.wdata = byte_set;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bfi_pkg::S_CLEAR;
            r_clr      <= '0;
            r_clr_out  <= 1'b0;
            r_p1_valid <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p1_valid <= (r_state == bfi_pkg::S_PROBE);
            r_wr_valid <= p1_write;
            if (r_state == bfi_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (accept) begin
                r_clr     <= '0;
                r_clr_out <= (i_opcode == bfi_pkg::OP_CLEAR);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_p1_addr;
        r_wr_data <= byte_set;
        if (accept) begin
            r_op    <= i_opcode;
            r_hash  <= i_key_hash;
            r_delta <= delta_in;
            r_m     <= i_m;
            r_k     <= i_k;
            r_hit   <= (i_opcode == bfi_pkg::OP_QUERY) && !i_key_empty;
        end
        case (r_state)
            bfi_pkg::S_FIX: begin
                r_pos <= i_mod_rem[0];
                r_d   <= i_mod_rem[1];
                r_w   <= (w_inc == r_m) ? '0 : w_inc[PW-1:0];
            end
            bfi_pkg::S_ADJ: begin
                r_dw  <= dw_sum[PW-1:0];
                r_cnt <= '0;
            end
            bfi_pkg::S_PROBE: begin
                r_p1_addr <= r_pos[PW-1:3];
                r_p1_bit  <= r_pos[2:0];
                r_pos     <= pos_nxt;
                r_hash    <= hsum[bfi_pkg::HASH_W-1:0];
                r_cnt     <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
        if (r_p1_valid && (r_op == bfi_pkg::OP_QUERY)) begin
            r_hit <= r_hit & byte_cur[r_p1_bit];
        end
    end

endmodule
`default_nettype wire

>>> design/bloom_filter_insert_query.sv
// Bloom filter bit store with double hashing over a 8192 x 8 bit memory.
// Command channel: present opcode, key_hash and key_empty with start high;
// the item is taken at the clock edge where start is high and busy is low.
// Opcodes: insert sets the probe bits, query checks them, clear wipes the
// store. Every item yields exactly one result, shown on o_maybe_present for
// a single cycle while o_valid is high; the receiver cannot stall it.
// Insert and query run in steps for k probes: a remainder unit (two bits
// per cycle) reduces the hash, its rotation and the 32-bit wrap term
// modulo the filter size, the FIX and ADJ steps combine them, then one
// probe issues per cycle into the single memory read port with write-back
// forwarding. An empty-key query or unused opcode skips these steps.
// A clear walks the memory one byte per cycle, then raises o_valid.
// After reset the same sweep runs with busy high, and the registers
// return to hash_count 6 and filter_bits 65536.
// Configuration: write i_cfg_data to register i_cfg_idx (0 hash_count,
// 1 filter_bits) while the block is idle.
`default_nettype none
module bloom_filter_insert_query (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_opcode,
    input  wire logic [31:0]                 i_key_hash,
    input  wire logic                        i_key_empty,
    output logic                             o_valid,
    output logic                             o_maybe_present,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [bfi_pkg::CFG_W-1:0]   i_cfg_data
);

    logic [bfi_pkg::K_W-1:0]   r_hash_count;
    logic [bfi_pkg::CFG_W-1:0] r_filter_bits;

    logic [bfi_pkg::CFG_W-1:0] fb_min;
    logic [bfi_pkg::CFG_W:0]   fb_round;
    logic [bfi_pkg::M_W-1:0]   eff_m;
    logic [bfi_pkg::K_W-1:0]   eff_k;

    logic                                              mod_start;
    logic                                              mod_done;
    logic [bfi_pkg::LANES-1:0][bfi_pkg::HASH_W-1:0]    mod_div;
    logic [bfi_pkg::LANES-1:0][bfi_pkg::POS_W-1:0]     mod_rem;
    bfi_pkg::t_ram_req                                 ram_req;
    logic [7:0]                                        ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count  <= bfi_pkg::HASH_COUNT_RST;
            r_filter_bits <= bfi_pkg::FILTER_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfi_pkg::REG_HASH_COUNT:  r_hash_count  <= i_cfg_data[bfi_pkg::K_W-1:0];
                bfi_pkg::REG_FILTER_BITS: r_filter_bits <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        fb_min   = (r_filter_bits < bfi_pkg::CFG_W'(bfi_pkg::MIN_BITS))
                   ? bfi_pkg::CFG_W'(bfi_pkg::MIN_BITS) : r_filter_bits;
        fb_round = ({1'b0, fb_min} + (bfi_pkg::CFG_W+1)'(7)) & ~((bfi_pkg::CFG_W+1)'(7));
        eff_m    = (fb_round > (bfi_pkg::CFG_W+1)'(bfi_pkg::STORE_BITS))
                   ? bfi_pkg::M_W'(bfi_pkg::STORE_BITS) : fb_round[bfi_pkg::M_W-1:0];
        if (r_hash_count == '0) begin
            eff_k = bfi_pkg::K_W'(1);
        end else if (r_hash_count > bfi_pkg::K_W'(bfi_pkg::MAX_HASHES)) begin
            eff_k = bfi_pkg::K_W'(bfi_pkg::MAX_HASHES);
        end else begin
            eff_k = r_hash_count;
        end
    end

    bfi_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_opcode        (i_opcode),
        .i_key_hash      (i_key_hash),
        .i_key_empty     (i_key_empty),
        .i_m             (eff_m),
        .i_k             (eff_k),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_maybe_present (o_maybe_present),
        .o_mod_start     (mod_start),
        .o_mod_div       (mod_div),
        .i_mod_done      (mod_done),
        .i_mod_rem       (mod_rem),
        .o_ram_req       (ram_req),
        .i_ram_rdata     (ram_rdata)
    );

    bfi_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_m     (eff_m),
        .i_div   (mod_div),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    bfi_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

>>> design/bfi_checker.sv
`default_nettype none
module bfi_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic o_maybe_present
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after item taken");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while idle");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_hit_qualified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_maybe_present)
        else $error("maybe_present without strobe");

    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (busy && !o_valid))
        else $error("block not sweeping after reset");

endmodule

bind bloom_filter_insert_query bfi_checker u_bfi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_maybe_present (o_maybe_present)
);
`default_nettype wire

>>> tb/bloom_filter_checker.sv
`timescale 1ns / 1ps
module bloom_filter_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_busy,
    input  wire logic [1:0]                i_opcode,
    input  wire logic [31:0]               i_key_hash,
    input  wire logic                      i_key_empty,
    input  wire logic                      i_valid,
    input  wire logic                      i_maybe_present,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [bfi_pkg::CFG_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import bfi_pkg::*;

    logic [7:0]       filter_bytes [STORE_BYTES];
    logic [K_W-1:0]   probe_count;
    logic [CFG_W-1:0] filter_size;
    logic             expected_answers [$];
    int               failures = 0;

    function automatic logic probe_answer(input logic [1:0] op, input logic [31:0] hash,
                                          input logic empty);
        int unsigned m;
        int unsigned k;
        int unsigned pos;
        int unsigned addr;
        int unsigned j;
        logic [31:0] h;
        logic [31:0] delta;
        logic        found;
        m = 32'(filter_size);
        if (m < MIN_BITS) begin
            m = MIN_BITS;
        end
        m = (m + 7) & ~32'd7;
        if (m > STORE_BITS) begin
            m = STORE_BITS;
        end
        k = 32'(probe_count);
        if (k < 1) begin
            k = 1;
        end
        if (k > MAX_HASHES) begin
            k = MAX_HASHES;
        end
        h = hash;
        delta = (hash >> ROT_RIGHT) | (hash << (HASH_W - ROT_RIGHT));
        found = 1'b0;
        case (op)
            OP_INSERT: begin
                for (j = 0; j < k; j++) begin
                    pos = h % m;
                    addr = (pos >> 3) % STORE_BYTES;
                    filter_bytes[addr[ADDR_W-1:0]][pos[2:0]] = 1'b1;
                    h = h + delta;
                end
            end
            OP_QUERY: begin
                if (!empty) begin
                    found = 1'b1;
                    for (j = 0; j < k && found; j++) begin
                        pos = h % m;
                        addr = (pos >> 3) % STORE_BYTES;
                        if (!filter_bytes[addr[ADDR_W-1:0]][pos[2:0]]) begin
                            found = 1'b0;
                        end
                        h = h + delta;
                    end
                end
            end
            OP_CLEAR: begin
                foreach (filter_bytes[i]) begin
                    filter_bytes[i] = 8'd0;
                end
            end
            default: begin
            end
        endcase
        return found;
    endfunction

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            foreach (filter_bytes[i]) begin
                filter_bytes[i] = 8'd0;
            end
            probe_count = HASH_COUNT_RST;
            filter_size = FILTER_BITS_RST;
            expected_answers.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HASH_COUNT:  probe_count = i_cfg_data[K_W-1:0];
                    REG_FILTER_BITS: filter_size = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_valid) begin
                if (expected_answers.size() == 0) begin
                    $error("maybe_present: result with no item outstanding, actual %0b",
                           i_maybe_present);
                    failures++;
                end else begin
                    want = expected_answers.pop_front();
                    if (want !== i_maybe_present) begin
                        $error("maybe_present: expected %0b, actual %0b", want,
                               i_maybe_present);
                        failures++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_answers.push_back(probe_answer(i_opcode, i_key_hash, i_key_empty));
            end
        end
        o_pending <= expected_answers.size();
        o_errors <= failures;
    end

endmodule

>>> tb/tb_bloom_filter_insert_query.sv
`timescale 1ns / 1ps
module tb_bloom_filter_insert_query;
    import bfi_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         STALL_LIMIT  = 40000;
    localparam int         FIXED_PHASES = 6;
    localparam int         PHASES       = 10;
    localparam int         PHASE_ITEMS  = 150;
    localparam int         POOL_DEPTH   = 64;
    localparam int PHASE_HASH_COUNT  [FIXED_PHASES] = '{1, 30, 0, 31, 5, 3};
    localparam int PHASE_FILTER_BITS [FIXED_PHASES] = '{64, 65536, 0, 131071, 200, 65535};
    localparam int PHASE_IDLE [4] = '{0, 82, 23, 0};

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_opcode;
    logic [31:0]       i_key_hash;
    logic              i_key_empty;
    logic              o_valid;
    logic              o_maybe_present;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    int                error_count;
    int                pending_answers;
    int                stall_cycles;
    int                idle_pct;
    logic [31:0]       inserted_keys [$];

    bloom_filter_insert_query uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_key_hash      (i_key_hash),
        .i_key_empty     (i_key_empty),
        .o_valid         (o_valid),
        .o_maybe_present (o_maybe_present),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    bloom_filter_checker answer_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_opcode        (i_opcode),
        .i_key_hash      (i_key_hash),
        .i_key_empty     (i_key_empty),
        .i_valid         (o_valid),
        .i_maybe_present (o_maybe_present),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (error_count),
        .o_pending       (pending_answers)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("bloom_filter_insert_query test failed");
            $finish;
        end
    end

    task automatic issue_command(input logic [1:0] op, input logic [31:0] hash,
                                 input logic empty);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            i_key_hash <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_key_hash <= hash;
        i_key_empty <= empty;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_answers != 0 || busy);
    endtask

    task automatic write_config(input int hash_count, input int filter_bits);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_HASH_COUNT;
        i_cfg_data <= CFG_W'(hash_count);
        @(posedge i_clk);
        i_cfg_idx <= REG_FILTER_BITS;
        i_cfg_data <= CFG_W'(filter_bits);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_command();
        int          r;
        logic [31:0] h;
        logic        empty;
        r = $urandom_range(999);
        if (r < 5) begin
            inserted_keys.delete();
            issue_command(OP_CLEAR, $urandom, 1'($urandom_range(1)));
        end else if (r < 15) begin
            issue_command(OP_UNUSED, $urandom, 1'($urandom_range(1)));
        end else if (r < 420) begin
            h = $urandom;
            inserted_keys.push_back(h);
            if (inserted_keys.size() > POOL_DEPTH) begin
                void'(inserted_keys.pop_front());
            end
            issue_command(OP_INSERT, h, 1'($urandom_range(1)));
        end else begin
            empty = ($urandom_range(19) == 0);
            if (inserted_keys.size() != 0 && $urandom_range(99) < 60) begin
                h = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
                if ($urandom_range(9) == 0) begin
                    h = h ^ (32'd1 << $urandom_range(31));
                end
            end else begin
                h = $urandom;
            end
            issue_command(OP_QUERY, h, empty);
        end
    endtask

    initial begin
        int hc;
        int fb;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_INSERT;
        i_key_hash = 32'd0;
        i_key_empty = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_HASH_COUNT;
        i_cfg_data = '0;
        stall_cycles = 0;
        idle_pct = 23;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue_command(OP_QUERY, 32'h0000_0000, 1'b0);
        issue_command(OP_INSERT, 32'h0000_0000, 1'b0);
        issue_command(OP_QUERY, 32'h0000_0000, 1'b0);
        issue_command(OP_QUERY, 32'h0000_0000, 1'b1);
        issue_command(OP_INSERT, 32'hFFFF_FFFF, 1'b1);
        issue_command(OP_QUERY, 32'hFFFF_FFFF, 1'b0);
        issue_command(OP_QUERY, 32'h1234_5678, 1'b0);
        issue_command(OP_UNUSED, 32'h1234_5678, 1'b1);
        issue_command(OP_QUERY, 32'h1234_5678, 1'b0);
        issue_command(OP_QUERY, 32'h0000_0000, 1'b0);
        issue_command(OP_INSERT, 32'h8000_0001, 1'b0);
        issue_command(OP_QUERY, 32'h8000_0001, 1'b0);
        issue_command(OP_QUERY, 32'h0001_FFFF, 1'b0);
        issue_command(OP_CLEAR, 32'h0000_0000, 1'b0);
        issue_command(OP_QUERY, 32'h0000_0000, 1'b0);
        issue_command(OP_QUERY, 32'hFFFF_FFFF, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            if (p < FIXED_PHASES) begin
                hc = PHASE_HASH_COUNT[p];
                fb = PHASE_FILTER_BITS[p];
            end else begin
                hc = $urandom_range(31);
                case ($urandom_range(3))
                    0, 1: fb = $urandom_range(200);
                    2: fb = $urandom_range(4096);
                    default: fb = $urandom_range(131071);
                endcase
            end
            write_config(hc, fb);
            idle_pct = PHASE_IDLE[p % 4];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_command();
            end
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && pending_answers == 0) begin
            $display("bloom_filter_insert_query test passed");
        end else begin
            $display("bloom_filter_insert_query test failed");
        end
        $finish;
    end

endmodule
